// ===== design/three_axis_velocity_estimator_defines.svh =====
// ----------------------------------------------------------------------------
// three_axis_velocity_estimator_defines
// assertion macros used by the velocity estimator
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_VELOCITY_ESTIMATOR_DEFINES_SVH
`define THREE_AXIS_VELOCITY_ESTIMATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TAVE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during rst
`define TAVE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/tave_pkg.sv =====
// ----------------------------------------------------------------------------
// tave_pkg
// types, constants and helpers of the three-axis velocity estimator
// ----------------------------------------------------------------------------
package tave_pkg;

  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic signed [17:0] WRAP_LIMIT = 18'sd2700;
  localparam logic signed [17:0] WRAP_NEG   = -18'sd2700;
  localparam logic signed [17:0] WRAP_STEP  = 18'sd3600;

  localparam logic [15:0] INTERVAL_RESET = 16'd20;

  localparam int NUM_W     = 31;
  localparam int DIV_STEPS = NUM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PREP,
    ST_DIV,
    ST_STORE,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // |d| * 100 by shifts and adds
  function automatic logic [NUM_W-1:0] mag_x100(input logic signed [24:0] d);
    logic [24:0] mag;
    begin
      mag = d[24] ? 25'(-d) : 25'(d);
      return (NUM_W'(mag) << 6) + (NUM_W'(mag) << 5) + (NUM_W'(mag) << 2);
    end
  endfunction

endpackage

// ===== design/tave_if.sv =====
// ----------------------------------------------------------------------------
// tave_if
// sample and result channels of the velocity estimator
// ----------------------------------------------------------------------------
interface tave_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        now_ms;
  logic signed [23:0] x_pos;
  logic signed [23:0] y_pos;
  logic signed [15:0] heading;

  modport source (output valid, command, now_ms, x_pos, y_pos, heading, input ready);
  modport sink   (input valid, command, now_ms, x_pos, y_pos, heading, output ready);
endinterface

interface tave_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_speed;
  logic signed [31:0] y_speed;
  logic signed [31:0] turn_speed;
  logic               updated;
  logic               mode;

  modport source (output valid, x_speed, y_speed, turn_speed, updated, mode, input ready);
  modport sink   (input valid, x_speed, y_speed, turn_speed, updated, mode, output ready);
endinterface

// ===== design/three_axis_velocity_estimator.sv =====
// ----------------------------------------------------------------------------
// three_axis_velocity_estimator
// x, y and turn velocity from millisecond position requests
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  sample    in    valid/ready    command, now_ms, x_pos, y_pos, heading
//  result    out   valid/ready    x_speed, y_speed, turn_speed, updated, mode
//  cfg       in    cfg_wr_en      cfg_wr_data (sample_interval_ms)
//
//  a request that recomputes velocity passes decide, prepare, 31 steps of three
//  bit-serial dividers, store and push on its way from acceptance to the result
//  register; start, stop and not-due requests pass decide and push only
//  one request in flight; the next is taken while the result waits
//  rst is synchronous and clears state, interval returns to 20
// ----------------------------------------------------------------------------
`include "three_axis_velocity_estimator_defines.svh"

module three_axis_velocity_estimator
  import tave_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  tave_sample_if.sink  sample,
  tave_result_if.source result
);

  state_t state, state_next;

  logic [15:0]        interval;
  logic [1:0]         cmd_q;
  logic [31:0]        now_q;
  logic signed [23:0] x_q, y_q;
  logic signed [15:0] h_q;

  logic               run_mode;
  logic [31:0]        last_time;
  logic signed [23:0] last_x, last_y;
  logic signed [16:0] last_heading;
  logic signed [31:0] speed_x, speed_y, speed_turn;
  logic               upd_q;

  logic [31:0]        elapsed_q;
  logic signed [24:0] dx_q, dy_q;
  logic signed [17:0] dh_q;
  logic signed [16:0] hc_q;

  logic [4:0]         step_cnt;
  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_turn;
  logic               out_upd, out_mode;

  logic               take;
  logic               push;
  div_ctrl_t          div_ctrl;

  logic [31:0]        elapsed;
  logic [15:0]        interval_eff;
  logic               due;
  logic signed [16:0] h_ext;
  logic signed [17:0] dh_raw;
  logic signed [17:0] dh_fix;
  logic signed [16:0] h_fix;

  logic signed [31:0] q_x, q_y, q_turn;

  // decide-stage arithmetic
  always_comb begin
    elapsed      = now_q - last_time;
    interval_eff = (interval == '0) ? 16'd1 : interval;
    due          = run_mode && (elapsed >= {16'd0, interval_eff});
    h_ext        = {h_q[15], h_q};
    dh_raw       = 18'({h_ext[16], h_ext}) - 18'({last_heading[16], last_heading});
    dh_fix       = dh_raw;
    h_fix        = h_ext;
    if (dh_raw > WRAP_LIMIT) begin
      dh_fix = dh_raw - WRAP_STEP;
      h_fix  = h_ext - WRAP_STEP[16:0];
    end else if (dh_raw < WRAP_NEG) begin
      dh_fix = dh_raw + WRAP_STEP;
      h_fix  = h_ext + WRAP_STEP[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    take          = 1'b0;
    push          = 1'b0;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        take = sample.valid;
        if (sample.valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (cmd_q != CMD_START && cmd_q != CMD_STOP && due) begin
          state_next = ST_PREP;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PREP: begin
        div_ctrl.load = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        if (step_cnt == 5'(DIV_STEPS - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid || result.ready) begin
          push       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign sample.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      interval <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q <= sample.command;
      now_q <= sample.now_ms;
      x_q   <= sample.x_pos;
      y_q   <= sample.y_pos;
      h_q   <= sample.heading;
    end
    if (state == ST_DECIDE) begin
      elapsed_q <= elapsed;
      dx_q      <= 25'({x_q[23], x_q}) - 25'({last_x[23], last_x});
      dy_q      <= 25'({y_q[23], y_q}) - 25'({last_y[23], last_y});
      dh_q      <= dh_fix;
      hc_q      <= h_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      step_cnt <= step_cnt + 5'd1;
    end else begin
      step_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode     <= 1'b0;
      last_time    <= '0;
      last_x       <= '0;
      last_y       <= '0;
      last_heading <= '0;
      speed_x      <= '0;
      speed_y      <= '0;
      speed_turn   <= '0;
      upd_q        <= 1'b0;
    end else if (state == ST_DECIDE) begin
      upd_q <= 1'b0;
      if (cmd_q == CMD_START) begin
        run_mode     <= 1'b1;
        last_time    <= now_q;
        last_x       <= x_q;
        last_y       <= y_q;
        last_heading <= h_ext;
        speed_x      <= '0;
        speed_y      <= '0;
        speed_turn   <= '0;
      end else if (cmd_q == CMD_STOP) begin
        run_mode   <= 1'b0;
        speed_x    <= '0;
        speed_y    <= '0;
        speed_turn <= '0;
      end
    end else if (state == ST_STORE) begin
      upd_q        <= 1'b1;
      last_time    <= now_q;
      last_x       <= x_q;
      last_y       <= y_q;
      last_heading <= hc_q;
      speed_x      <= q_x;
      speed_y      <= q_y;
      speed_turn   <= q_turn;
    end
  end

  tave_div u_div_x (
    .clk   (clk),
    .ctrl  (div_ctrl),
    .numer (mag_x100(dx_q)),
    .neg   (dx_q[24]),
    .denom (elapsed_q),
    .quot  (q_x)
  );

  tave_div u_div_y (
    .clk   (clk),
    .ctrl  (div_ctrl),
    .numer (mag_x100(dy_q)),
    .neg   (dy_q[24]),
    .denom (elapsed_q),
    .quot  (q_y)
  );

  tave_div u_div_turn (
    .clk   (clk),
    .ctrl  (div_ctrl),
    .numer (mag_x100(25'(dh_q))),
    .neg   (dh_q[17]),
    .denom (elapsed_q),
    .quot  (q_turn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_x    <= speed_x;
      out_y    <= speed_y;
      out_turn <= speed_turn;
      out_upd  <= upd_q;
      out_mode <= run_mode;
    end
  end

  assign result.valid      = out_valid;
  assign result.x_speed    = out_x;
  assign result.y_speed    = out_y;
  assign result.turn_speed = out_turn;
  assign result.updated    = out_upd;
  assign result.mode       = out_mode;

  `TAVE_ASSERT_NEXT(a_div_ends, (state == ST_DIV) && (step_cnt == 5'(DIV_STEPS - 1)), state == ST_STORE)
  `TAVE_ASSERT_IMPL(a_stop_only, $fell(run_mode) && !$past(rst), $past(cmd_q) == CMD_STOP)
  `TAVE_ASSERT_IMPL(a_push_src, $rose(out_valid), $past(state) == ST_PUSH)
  `TAVE_ASSERT_IMPL(a_upd_mode, (state == ST_PUSH) && upd_q, run_mode)

endmodule

// ===== design/tave_div.sv =====
// ----------------------------------------------------------------------------
// tave_div
// bit-serial restoring divider, one quotient bit per step, signed result
// ----------------------------------------------------------------------------
module tave_div
  import tave_pkg::*;
(
  input  logic               clk,
  input  div_ctrl_t          ctrl,
  input  logic [NUM_W-1:0]   numer,
  input  logic               neg,
  input  logic [31:0]        denom,
  output logic signed [31:0] quot
);

  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] q;
  logic [31:0]      rem;
  logic [31:0]      den;
  logic             neg_q;
  logic [32:0]      trial;
  logic             fits;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num_sh <= numer;
      q      <= '0;
      rem    <= '0;
      den    <= denom;
      neg_q  <= neg;
    end else if (ctrl.step) begin
      num_sh <= num_sh << 1;
      q      <= {q[NUM_W-2:0], fits};
      rem    <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
    end
  end

  assign quot = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule
